/* rtl/c3ps_pkg.sv */
// ---------------------------------------------------------------------------
// c3ps_pkg: shared types and constants of the 3x3 pixel stream convolver
// Field widths, result record, register indexes and register reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package c3ps_pkg;

  localparam int PIX_W      = 8;
  localparam int COEF_W     = 8;
  localparam int KROW_W     = 3 * COEF_W;
  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = KROW_W;
  localparam int COORD_W    = 10;
  localparam int RESP_W     = 20;
  localparam int PROD_W     = PIX_W + 1 + COEF_W;
  localparam int RSUM_W     = PROD_W + 2;
  localparam int TOT_W      = RSUM_W + 2;

  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;
  // Sobel x kernel: left coefficient in the low byte
  localparam logic [KROW_W-1:0] KROW_TOP_RST = 24'h0100FF;
  localparam logic [KROW_W-1:0] KROW_MID_RST = 24'h0200FE;
  localparam logic [KROW_W-1:0] KROW_BOT_RST = 24'h0100FF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH   = 3'd0,
    CFG_HEIGHT  = 3'd1,
    CFG_KROW_T  = 3'd2,
    CFG_KROW_M  = 3'd3,
    CFG_KROW_B  = 3'd4
  } cfg_idx_e;

  typedef logic [PIX_W-1:0]          pix_t;
  typedef logic signed [RESP_W-1:0]  resp_t;
  typedef logic [COORD_W-1:0]        coord_t;

  typedef struct packed {
    resp_t  response;
    coord_t center_row;
    coord_t center_col;
    logic   frame_end;
  } res_t;

endpackage

`default_nettype wire

/* rtl/c3ps_if.sv */
// ---------------------------------------------------------------------------
// c3ps_if: stream channels of the 3x3 pixel stream convolver
// Pixel request channel and result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface c3ps_pix_if
  import c3ps_pkg::*;
();
  logic valid;
  logic ready;
  pix_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface c3ps_res_if
  import c3ps_pkg::*;
();
  logic   valid;
  logic   ready;
  resp_t  response;
  coord_t center_row;
  coord_t center_col;
  logic   frame_end;

  modport source (output valid, output response, output center_row,
                  output center_col, output frame_end, input ready);
  modport sink   (input valid, input response, input center_row,
                  input center_col, input frame_end, output ready);
endinterface

`default_nettype wire

/* rtl/c3ps_ram.sv */
// ---------------------------------------------------------------------------
// c3ps_ram: generic simple dual port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module c3ps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/c3ps_out_fifo.sv */
// ---------------------------------------------------------------------------
// c3ps_out_fifo: result queue
// Holds finished results while the receiver stalls; head shown directly.
// ---------------------------------------------------------------------------
`default_nettype none

module c3ps_out_fifo
  import c3ps_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t data_i,
  input  wire logic pop_i,
  output logic      valid_o,
  output res_t      data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != CW'(DEPTH)) || pop_i)
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("result queue underflow");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q == rd_ptr_q) |-> (count_q == '0) || (count_q == CW'(DEPTH)))
    else $error("result queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

/* rtl/conv3x3_pixel_stream_core.sv */
// ---------------------------------------------------------------------------
// conv3x3_pixel_stream_core: 3x3 signed convolution over a raster pixel stream
// Line RAM, 3x3 window, nine-tap multiply and adder tree, result queue.
// ---------------------------------------------------------------------------
// Pixels enter on pix_i in raster order, one request per pixel; the frame
// position is tracked inside. Each interior pixel yields one result on res_o
// (weighted sum, center row and column, frame_end on the last one of the
// frame) when the pixel below-right of it arrives; border pixels yield none.
// Sizes and the three kernel rows go on the cfg port; the user must write
// them only while idle, which the block itself does not enforce.
// Throughput: one pixel per clock while pix_i.ready is high, set by the line
// RAM read-modify-write (read in the accept cycle, written back in the next).
// A result passes RAM read, window, products, row sums, then the result queue.
// A stalled receiver is absorbed by an 8-entry result queue; pix_i.ready
// falls when 8 requests are outstanding and rises again as results drain.
// Reset: position returns to the frame start, sizes to 640x480 and the
// kernel to Sobel x; the line RAM is not cleared, as the first two rows of
// a frame fill it before any result uses it.
// ---------------------------------------------------------------------------
`default_nettype none

module conv3x3_pixel_stream_core
  import c3ps_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  c3ps_pix_if.sink                   pix_i,
  c3ps_res_if.source                 res_o
);

  localparam int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW        = $clog2(MAX_WIDTH + 1);
  localparam int RW        = $clog2(MAX_HEIGHT + 1);
  localparam int TWW       = (CW > SIZE_W) ? CW : SIZE_W;
  localparam int TWH       = (RW > SIZE_W) ? RW : SIZE_W;
  localparam int W_RST     = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
  localparam int H_RST     = (HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RST;
  localparam int OUT_DEPTH = 8;
  localparam int OW        = $clog2(OUT_DEPTH + 1);
  localparam int LW        = 2 * PIX_W;

  // ---------------- configuration ----------------
  logic [CW-1:0]     width_q;
  logic [RW-1:0]     height_q;
  logic [KROW_W-1:0] krow_q [3];
  logic [TWW-1:0]    wcfg;
  logic [TWH-1:0]    hcfg;
  logic [CW-1:0]     wclamp;
  logic [RW-1:0]     hclamp;

  always_comb begin
    wcfg = TWW'(cfg_data_i[SIZE_W-1:0]);
    hcfg = TWH'(cfg_data_i[SIZE_W-1:0]);
    if (wcfg < TWW'(3)) begin
      wclamp = CW'(3);
    end else if (wcfg > TWW'(MAX_WIDTH)) begin
      wclamp = CW'(MAX_WIDTH);
    end else begin
      wclamp = wcfg[CW-1:0];
    end
    if (hcfg < TWH'(3)) begin
      hclamp = RW'(3);
    end else if (hcfg > TWH'(MAX_HEIGHT)) begin
      hclamp = RW'(MAX_HEIGHT);
    end else begin
      hclamp = hcfg[RW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= CW'(W_RST);
      height_q  <= RW'(H_RST);
      krow_q[0] <= KROW_TOP_RST;
      krow_q[1] <= KROW_MID_RST;
      krow_q[2] <= KROW_BOT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  width_q   <= wclamp;
        CFG_HEIGHT: height_q  <= hclamp;
        CFG_KROW_T: krow_q[0] <= cfg_data_i[KROW_W-1:0];
        CFG_KROW_M: krow_q[1] <= cfg_data_i[KROW_W-1:0];
        CFG_KROW_B: krow_q[2] <= cfg_data_i[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- position and request accept ----------------
  logic [CW-1:0] col_q, col_at;
  logic [RW-1:0] row_q, row_inc, row_at;
  logic          accept, hit_at, last_at;
  logic [OW-1:0] occ_q;
  logic          drop, pop;

  assign pix_i.ready = (occ_q < OW'(OUT_DEPTH));
  assign accept      = pix_i.valid && pix_i.ready;

  always_comb begin
    if (col_q >= width_q) begin
      col_at  = '0;
      row_inc = row_q + RW'(1);
    end else begin
      col_at  = col_q;
      row_inc = row_q;
    end
    row_at  = (row_inc >= height_q) ? '0 : row_inc;
    hit_at  = (row_at >= RW'(2)) && (col_at >= CW'(2));
    last_at = (row_at == height_q - RW'(1)) && (col_at == width_q - CW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_at + CW'(1);
      row_q <= row_at;
    end
  end

  // ---------------- stage 1: line RAM read pending ----------------
  logic          s1_valid_q, s1_hit_q, s1_last_q;
  pix_t          s1_pix_q;
  logic [AW-1:0] s1_addr_q;
  coord_t        s1_row_q, s1_col_q;
  logic [LW-1:0] line_rdata;
  logic [31:0]   row_m1, col_m1;

  assign row_m1 = 32'(row_at) - 32'd1;
  assign col_m1 = 32'(col_at) - 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pix_i.pixel;
      s1_addr_q <= col_at[AW-1:0];
      s1_hit_q  <= hit_at;
      s1_last_q <= last_at;
      s1_row_q  <= row_m1[COORD_W-1:0];
      s1_col_q  <= col_m1[COORD_W-1:0];
    end
  end

  // Upper byte: older row, lower byte: newer row. Write back shifted.
  c3ps_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i ({line_rdata[PIX_W-1:0], s1_pix_q}),
    .re_i    (accept),
    .raddr_i (col_at[AW-1:0]),
    .rdata_o (line_rdata)
  );

  // ---------------- stage 2: window ----------------
  pix_t   win_q [3][3];
  logic   s2_valid_q, s2_last_q;
  coord_t s2_row_q, s2_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[k][j] <= '0;
        end
      end
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_valid_q) begin
        for (int k = 0; k < 3; k++) begin
          win_q[k][0] <= win_q[k][1];
          win_q[k][1] <= win_q[k][2];
        end
        win_q[0][2] <= line_rdata[LW-1:PIX_W];
        win_q[1][2] <= line_rdata[PIX_W-1:0];
        win_q[2][2] <= s1_pix_q;
      end
      s2_valid_q <= s1_valid_q && s1_hit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_last_q <= s1_last_q;
    s2_row_q  <= s1_row_q;
    s2_col_q  <= s1_col_q;
  end

  // ---------------- stage 3: products ----------------
  logic signed [PROD_W-1:0] prod_d [3][3];
  logic signed [PROD_W-1:0] prod_q [3][3];
  logic                     s3_valid_q, s3_last_q;
  coord_t                   s3_row_q, s3_col_q;

  for (genvar k = 0; k < 3; k++) begin : g_prow
    for (genvar j = 0; j < 3; j++) begin : g_pcol
      logic signed [COEF_W-1:0] coef;
      assign coef        = $signed(krow_q[k][COEF_W*j +: COEF_W]);
      assign prod_d[k][j] = $signed({1'b0, win_q[k][j]}) * coef;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= prod_d;
    s3_last_q <= s2_last_q;
    s3_row_q  <= s2_row_q;
    s3_col_q  <= s2_col_q;
  end

  // ---------------- stage 4: row sums ----------------
  logic signed [RSUM_W-1:0] rsum_q [3];
  logic                     s4_valid_q, s4_last_q;
  coord_t                   s4_row_q, s4_col_q;
  logic signed [TOT_W-1:0]  total;
  res_t                     push_data, head;
  logic                     head_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      rsum_q[k] <= RSUM_W'(prod_q[k][0]) + RSUM_W'(prod_q[k][1])
                   + RSUM_W'(prod_q[k][2]);
    end
    s4_last_q <= s3_last_q;
    s4_row_q  <= s3_row_q;
    s4_col_q  <= s3_col_q;
  end

  assign total = TOT_W'(rsum_q[0]) + TOT_W'(rsum_q[1]) + TOT_W'(rsum_q[2]);

  always_comb begin
    push_data.response   = total[RESP_W-1:0];
    push_data.center_row = s4_row_q;
    push_data.center_col = s4_col_q;
    push_data.frame_end  = s4_last_q;
  end

  // ---------------- result queue and request credit ----------------
  c3ps_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s4_valid_q),
    .data_i  (push_data),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head)
  );

  assign res_o.valid      = head_valid;
  assign res_o.response   = head.response;
  assign res_o.center_row = head.center_row;
  assign res_o.center_col = head.center_col;
  assign res_o.frame_end  = head.frame_end;

  assign pop  = head_valid && res_o.ready;
  // border pixels leave the pipe without a result
  assign drop = s1_valid_q && !s1_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_q + OW'(accept) - OW'(drop) - OW'(pop);
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(OUT_DEPTH))
    else $error("outstanding requests exceed result queue depth");

  a_occ_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drop || pop) |-> occ_q >= (OW'(drop) + OW'(pop)))
    else $error("request credit released without an outstanding request");

  a_rmw_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && accept) |-> (col_at[AW-1:0] != s1_addr_q))
    else $error("line RAM read overlaps pending write-back");

  a_hit_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && hit_at) |=> (s1_col_q != '0) && (s1_row_q != '0))
    else $error("result issued for a border position");
`endif

endmodule

`default_nettype wire
